@@ rtl/assert_macros.svh @@
// assertion macros shared by the front and back end rtl files of the window clique counter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define WCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define WCC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/wcc_pkg.sv @@
// shared types and constants of the window clique counter
`default_nettype none
package wcc_pkg;

	localparam int ANCHOR_W = 48;
	localparam int TOTAL_W = 63;
	localparam logic [ANCHOR_W-1:0] ANCHOR_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	localparam int WIDTH_W = 31;
	localparam int CLIQUE_W = 5;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 31'd16777;
	localparam logic [CLIQUE_W-1:0] CLIQUE_RESET = 5'd3;
	localparam logic [CLIQUE_W-1:0] CLIQUE_MAX = 5'd16;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPW = 1;

	typedef struct packed {
		logic [WIDTH_W-1:0] window_width;
		logic [CLIQUE_W-1:0] clique_size;
	} cfg_t;

	typedef struct packed {
		logic set_end;
		logic order_err;
	} item_tag_t;

endpackage
`default_nettype wire

@@ rtl/window_clique_counter.sv @@
// top level of the window clique counter: register port, front end, back end, window ram
//
//  channel   direction  transfer when               payload
//  sample    in         sample_valid & !sample_stall sample_value, set_end
//  result    out        result_valid & !result_stall anchor_groups .. end_of_set
//  config    in         psel & penable & pwrite      paddr, pwdata (prdata on reads)
//
// per item the back end drops the stale entries, then runs up to k-1 multiply-divide steps,
// k the clique size; each divide spans N bytes, N = ceil((48 + clog2(WINDOW_DEPTH+1))/8)
// (8 at the default depth), and yields eight quotient bits a cycle
// the front queue holds two items, so samples are taken while the back end works
// a waiting result holds its register; the back end then pauses before the next item
// reset is asynchronous and clears the window, total and flags; ram contents need none
`default_nettype none
module window_clique_counter
	import wcc_pkg::*;
#(
	parameter int WINDOW_DEPTH = 256,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic signed [VALUE_BITS-1:0] sample_value,
	input  wire logic                         set_end,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	output logic [ANCHOR_W-1:0]               anchor_groups,
	output logic [TOTAL_W-1:0]                running_total,
	output logic                              overflow_flag,
	output logic                              order_error,
	output logic                              end_of_set,
	output logic                              result_valid,
	input  wire logic                         result_stall
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic REG_WINDOW_WIDTH = 1'b0;
	localparam logic REG_CLIQUE_SIZE = 1'b1;

	cfg_t                         cfg_q;
	logic                         q_valid;
	logic signed [VALUE_BITS-1:0] q_value;
	item_tag_t                    q_tag;
	logic                         q_pop;
	logic [AW-1:0]                ram_rd_addr;
	logic signed [VALUE_BITS-1:0] ram_rd_data;
	logic                         ram_wr_en;
	logic [AW-1:0]                ram_wr_addr;
	logic signed [VALUE_BITS-1:0] ram_wr_data;
	logic                         cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_width <= WIDTH_RESET;
			cfg_q.clique_size <= CLIQUE_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WINDOW_WIDTH: cfg_q.window_width <= pwdata[WIDTH_W-1:0];
				REG_CLIQUE_SIZE: cfg_q.clique_size <= pwdata[CLIQUE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW_WIDTH: prdata = 32'(cfg_q.window_width);
			REG_CLIQUE_SIZE: prdata = 32'(cfg_q.clique_size);
			default: prdata = '0;
		endcase
	end

	wcc_front #(
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample_value(sample_value),
		.set_end(set_end),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.q_valid(q_valid),
		.q_value(q_value),
		.q_tag(q_tag),
		.q_pop(q_pop)
	);

	wcc_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk(clk),
		.wr_en(ram_wr_en),
		.wr_addr(ram_wr_addr),
		.wr_data(ram_wr_data),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	wcc_back #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_valid),
		.q_value(q_value),
		.q_tag(q_tag),
		.q_pop(q_pop),
		.ram_rd_addr(ram_rd_addr),
		.ram_rd_data(ram_rd_data),
		.ram_wr_en(ram_wr_en),
		.ram_wr_addr(ram_wr_addr),
		.ram_wr_data(ram_wr_data),
		.anchor_groups(anchor_groups),
		.running_total(running_total),
		.overflow_flag(overflow_flag),
		.order_error(order_error),
		.end_of_set(end_of_set),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
`default_nettype wire

@@ rtl/wcc_ram.sv @@
// generic single-port-write, registered-read ram
`default_nettype none
module wcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
`default_nettype wire

@@ rtl/wcc_front.sv @@
// input side: takes samples, flags descending values, queues them for the back end
`default_nettype none
`include "assert_macros.svh"
module wcc_front
	import wcc_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic signed [VALUE_BITS-1:0] sample_value,
	input  wire logic                         set_end,
	input  wire logic                         sample_valid,
	output logic                              sample_stall,
	output logic                              q_valid,
	output logic signed [VALUE_BITS-1:0]      q_value,
	output item_tag_t                         q_tag,
	input  wire logic                         q_pop
);

	logic signed [VALUE_BITS-1:0] qv_q [QUEUE_DEPTH];
	item_tag_t                    qt_q [QUEUE_DEPTH];
	logic [QPW-1:0]               wr_ptr_q;
	logic [QPW-1:0]               rd_ptr_q;
	logic [QPW:0]                 count_q;
	logic signed [VALUE_BITS-1:0] prev_q;
	logic                         first_q;
	logic                         push;
	logic                         order_err;

	assign sample_stall = (count_q == (QPW+1)'(QUEUE_DEPTH));
	assign push = sample_valid && !sample_stall;
	// first value of a set has no predecessor to compare against
	assign order_err = !first_q && (sample_value < prev_q);

	assign q_valid = (count_q != '0);
	assign q_value = qv_q[rd_ptr_q];
	assign q_tag = qt_q[rd_ptr_q];

	function automatic logic [QPW-1:0] qnext(input logic [QPW-1:0] p);
		return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + QPW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
			prev_q <= '0;
			first_q <= 1'b1;
		end else begin
			if (push) begin
				wr_ptr_q <= qnext(wr_ptr_q);
				prev_q <= sample_value;
				first_q <= set_end;
			end
			if (q_pop) begin
				rd_ptr_q <= qnext(rd_ptr_q);
			end
			if (push && !q_pop) begin
				count_q <= count_q + (QPW+1)'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - (QPW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qv_q[wr_ptr_q] <= sample_value;
			qt_q[wr_ptr_q] <= '{set_end: set_end, order_err: order_err};
		end
	end

	`WCC_ASSERT_NOW(a_queue_bound, 1'b1, count_q <= (QPW+1)'(QUEUE_DEPTH), "queue overfilled")
	`WCC_ASSERT_NOW(a_pop_nonempty, q_pop, count_q != '0, "pop from empty queue")
	`WCC_ASSERT_NEXT(a_first_after_end, push && set_end, first_q, "no new set after set end")

endmodule
`default_nettype wire

@@ rtl/wcc_back.sv @@
// back end: drops stale window entries, works out the binomial count, accumulates
`default_nettype none
`include "assert_macros.svh"
module wcc_back
	import wcc_pkg::*;
#(
	parameter int WINDOW_DEPTH = 256,
	parameter int VALUE_BITS = 32
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cfg_t                             cfg,
	input  wire logic                             q_valid,
	input  wire logic signed [VALUE_BITS-1:0]     q_value,
	input  wire item_tag_t                        q_tag,
	output logic                                  q_pop,
	output logic [$clog2(WINDOW_DEPTH)-1:0]       ram_rd_addr,
	input  wire logic signed [VALUE_BITS-1:0]     ram_rd_data,
	output logic                                  ram_wr_en,
	output logic [$clog2(WINDOW_DEPTH)-1:0]       ram_wr_addr,
	output logic signed [VALUE_BITS-1:0]          ram_wr_data,
	output logic [ANCHOR_W-1:0]                   anchor_groups,
	output logic [TOTAL_W-1:0]                    running_total,
	output logic                                  overflow_flag,
	output logic                                  order_error,
	output logic                                  end_of_set,
	output logic                                  result_valid,
	input  wire logic                             result_stall
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int HB = $clog2(WINDOW_DEPTH + 1);
	localparam int HW = (HB > 4) ? HB : 4;
	localparam int CMPW = (VALUE_BITS + 1 > WIDTH_W + 1) ? VALUE_BITS + 1 : WIDTH_W + 1;
	localparam int PW = ANCHOR_W + HB;
	localparam int NDIG = (PW + 7) / 8;
	localparam int DW = NDIG * 8;
	localparam int DCW = (NDIG > 1) ? $clog2(NDIG) : 1;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_MUL  = 5'b00100,
		S_DIV  = 5'b01000,
		S_DONE = 5'b10000
	} bk_state_t;

	bk_state_t                    state_q;
	logic [AW-1:0]                head_q;
	logic [AW-1:0]                tail_q;
	logic [HB-1:0]                held_q;
	logic [TOTAL_W-1:0]           total_q;
	logic                         ovf_flag_q;
	logic                         ord_flag_q;
	logic signed [VALUE_BITS-1:0] v_q;
	logic                         end_q;
	logic                         item_ord_q;
	logic [3:0]                   r_q;
	logic [3:0]                   i_q;
	logic [ANCHOR_W-1:0]          c_q;
	logic                         sat_q;
	logic [DW-1:0]                num_q;
	logic [3:0]                   rem_q;
	logic [DCW-1:0]               dig_q;
	logic                         result_valid_q;
	logic [ANCHOR_W-1:0]          anchor_q;
	logic [TOTAL_W-1:0]           total_out_q;
	logic                         ovf_out_q;
	logic                         ord_out_q;
	logic                         end_out_q;

	logic signed [CMPW-1:0]       v_ext;
	logic signed [CMPW-1:0]       e_ext;
	logic signed [CMPW-1:0]       w_ext;
	logic signed [CMPW-1:0]       diff;
	logic                         stale;
	logic [3:0]                   r_clamp;
	logic [4:0]                   div_d;
	logic                         i_ge_h;
	logic [HB-1:0]                mul_h;
	logic [PW-1:0]                prod;
	logic [4:0]                   dv_t;
	logic [3:0]                   dv_r;
	logic [7:0]                   dv_q;
	logic [DW-1:0]                quot;
	logic                         quot_sat;
	logic [TOTAL_W:0]             sum;
	logic                         tot_sat;
	logic                         full;
	logic                         commit;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		return (p == AW'(WINDOW_DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	// stale when the new value lies more than the width above the oldest entry
	assign v_ext = CMPW'(v_q);
	assign e_ext = CMPW'(ram_rd_data);
	assign w_ext = CMPW'(cfg.window_width);
	assign diff = v_ext - e_ext;
	assign stale = (held_q != '0) && (diff > w_ext);

	always_comb begin
		if (cfg.clique_size == '0) begin
			r_clamp = 4'd0;
		end else if (cfg.clique_size > CLIQUE_MAX) begin
			r_clamp = 4'(CLIQUE_MAX - 5'd1);
		end else begin
			r_clamp = 4'(cfg.clique_size - 5'd1);
		end
	end

	assign div_d = {1'b0, i_q} + 5'd1;
	assign i_ge_h = (HW'(i_q) >= HW'(held_q));
	assign mul_h = held_q - HB'(i_q);
	assign prod = PW'(c_q) * PW'(mul_h);

	// eight restoring steps per cycle, divisor at most fifteen
	always_comb begin
		dv_r = rem_q;
		dv_q = '0;
		for (int j = 7; j >= 0; j--) begin
			dv_t = {dv_r, num_q[DW-8+j]};
			if (dv_t >= div_d) begin
				dv_r = 4'(dv_t - div_d);
				dv_q[j] = 1'b1;
			end else begin
				dv_r = dv_t[3:0];
			end
		end
	end

	assign quot = {num_q[DW-9:0], dv_q};
	assign quot_sat = (quot > DW'(ANCHOR_MAX));

	assign sum = {1'b0, total_q} + (TOTAL_W+1)'(c_q);
	assign tot_sat = sum[TOTAL_W];
	assign full = (held_q == HB'(WINDOW_DEPTH));
	assign commit = (state_q == S_DONE) && (!result_valid_q || !result_stall);

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign ram_rd_addr = ((state_q == S_SCAN) && stale) ? ring_next(tail_q) : tail_q;
	assign ram_wr_en = commit;
	assign ram_wr_addr = head_q;
	assign ram_wr_data = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			held_q <= '0;
			total_q <= '0;
			ovf_flag_q <= 1'b0;
			ord_flag_q <= 1'b0;
			result_valid_q <= 1'b0;
			r_q <= '0;
			i_q <= '0;
			dig_q <= '0;
		end else begin
			if (commit) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						r_q <= r_clamp;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (stale) begin
						tail_q <= ring_next(tail_q);
						held_q <= held_q - HB'(1);
					end else begin
						i_q <= '0;
						state_q <= (r_q == '0) ? S_DONE : S_MUL;
					end
				end
				S_MUL: begin
					dig_q <= '0;
					state_q <= i_ge_h ? S_DONE : S_DIV;
				end
				S_DIV: begin
					dig_q <= dig_q + DCW'(1);
					if (dig_q == DCW'(NDIG - 1)) begin
						i_q <= i_q + 4'd1;
						if (quot_sat || (div_d == {1'b0, r_q})) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					if (commit) begin
						state_q <= S_IDLE;
						if (end_q) begin
							head_q <= '0;
							tail_q <= '0;
							held_q <= '0;
							total_q <= '0;
							ovf_flag_q <= 1'b0;
							ord_flag_q <= 1'b0;
						end else begin
							head_q <= ring_next(head_q);
							// full window: oldest entry gives way to the new one
							if (full) begin
								tail_q <= ring_next(tail_q);
							end else begin
								held_q <= held_q + HB'(1);
							end
							total_q <= tot_sat ? TOTAL_MAX : sum[TOTAL_W-1:0];
							ovf_flag_q <= ovf_flag_q || sat_q || tot_sat || full;
							ord_flag_q <= ord_flag_q || item_ord_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				v_q <= q_value;
				end_q <= q_tag.set_end;
				item_ord_q <= q_tag.order_err;
				sat_q <= 1'b0;
			end
			S_SCAN: begin
				c_q <= ANCHOR_W'(1);
			end
			S_MUL: begin
				if (i_ge_h) begin
					c_q <= '0;
				end
				num_q <= DW'(prod);
				rem_q <= '0;
			end
			S_DIV: begin
				num_q <= quot;
				rem_q <= dv_r;
				if (dig_q == DCW'(NDIG - 1)) begin
					if (quot_sat) begin
						c_q <= ANCHOR_MAX;
						sat_q <= 1'b1;
					end else begin
						c_q <= quot[ANCHOR_W-1:0];
					end
				end
			end
			S_DONE: begin
				if (commit) begin
					anchor_q <= c_q;
					total_out_q <= tot_sat ? TOTAL_MAX : sum[TOTAL_W-1:0];
					ovf_out_q <= ovf_flag_q || sat_q || tot_sat || full;
					ord_out_q <= ord_flag_q || item_ord_q;
					end_out_q <= end_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid = result_valid_q;
	assign anchor_groups = anchor_q;
	assign running_total = total_out_q;
	assign overflow_flag = ovf_out_q;
	assign order_error = ord_out_q;
	assign end_of_set = end_out_q;

	`WCC_ASSERT_NOW(a_held_bound, 1'b1, held_q <= HB'(WINDOW_DEPTH), "window holds too many entries")
	`WCC_ASSERT_NOW(a_rem_below_div, state_q == S_DIV, rem_q < div_d, "division remainder too large")
	`WCC_ASSERT_NEXT(a_set_cleared, commit && end_q, (held_q == '0) && (total_q == '0),
		"set state not cleared after last item")

endmodule
`default_nettype wire
